@@ rtl/core/psbl_pkg.sv @@
// Shared types, constants and codes for the prefix-sum bucket locator.
package psbl_pkg;

  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned IdxW       = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned CountW     = $clog2(MaxBuckets + 1);
  localparam int unsigned ValueW     = 32;
  localparam int unsigned BucketW    = 11;

  typedef enum logic [1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_QUERY   = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ZERO   = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_COMPARE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture an accepted request
    logic exec;         // finish a request that needs no search
    logic search_init;  // set up the search bounds
    logic rd;           // read the stored total at the midpoint
    logic step;         // narrow the bounds with the read total
    logic finish;       // deliver the search result
  } psbl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_ok;     // request is a query that needs a search
    logic lo_lt_hi;     // search interval still holds more than one entry
  } psbl_sts_t;

endpackage

@@ rtl/core/psbl_ctrl.sv @@
// Controller state machine sequencing requests and the binary search.
module psbl_ctrl
  import psbl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  psbl_sts_t sts_i,
  output psbl_cmd_t cmd_o,
  output logic      busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = sts_i.query_ok ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_d = sts_i.lo_lt_hi ? S_COMPARE : S_IDLE;
      end
      S_COMPARE: begin
        state_d = S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_DECIDE: begin
        cmd_o.search_init = sts_i.query_ok;
        cmd_o.exec        = !sts_i.query_ok;
      end
      S_READ: begin
        cmd_o.rd     = sts_i.lo_lt_hi;
        cmd_o.finish = !sts_i.lo_lt_hi;
      end
      S_COMPARE: begin
        cmd_o.step = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/core/psbl_dp.sv @@
// Datapath: running-total memory, counters, search bounds and result registers.
module psbl_dp
  import psbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psbl_cmd_t           cmd_i,
  input  logic [1:0]          func_i,
  input  logic [ValueW-1:0]   item_value_i,
  output psbl_sts_t           sts_o,
  output logic                done_o,
  output logic [BucketW-1:0]  bucket_number_o,
  output logic [1:0]          status_o
);

  logic [ValueW-1:0]  mem [MaxBuckets];

  func_e              func_q;
  logic [ValueW-1:0]  value_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [ValueW-1:0]  total_q, total_d;
  logic [IdxW-1:0]    lo_q, lo_d, hi_q, hi_d, mid;
  logic [ValueW-1:0]  rd_data_q;
  logic               done_q;
  logic [BucketW-1:0] bucket_q, bucket_d;
  status_e            status_q, status_d;

  logic [ValueW:0]    sum_ext;
  logic [ValueW-1:0]  sum_sat;
  logic               full, wr_en;
  logic [CountW-1:0]  count_m1;
  logic [IdxW:0]      lo_plus1;

  assign sum_ext  = {1'b0, total_q} + {1'b0, value_q};
  assign sum_sat  = sum_ext[ValueW] ? {ValueW{1'b1}} : sum_ext[ValueW-1:0];
  assign full     = (count_q == CountW'(MaxBuckets));
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign count_m1 = count_q - CountW'(1);
  assign lo_plus1 = {1'b0, lo_q} + (IdxW+1)'(1);
  assign wr_en    = cmd_i.exec && (func_q == FUNC_APPEND) && !full;

  assign sts_o.query_ok = (func_q == FUNC_QUERY) && (value_q != '0) &&
                          (count_q != '0) && (value_q <= total_q);
  assign sts_o.lo_lt_hi = (lo_q < hi_q);

  // Immediate results and table updates for requests that need no search, plus search setup, narrowing and result.
  always_comb begin
    count_d  = count_q;
    total_d  = total_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    bucket_d = bucket_q;
    status_d = status_q;
    if (cmd_i.exec) begin
      bucket_d = '0;
      status_d = ST_OK;
      unique case (func_q)
        FUNC_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            total_d = sum_sat;
            count_d = count_q + CountW'(1);
          end
        end
        FUNC_QUERY: begin
          status_d = (value_q == '0) ? ST_ZERO : ST_BEYOND;
        end
        FUNC_RESTART: begin
          count_d = '0;
          total_d = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
    if (cmd_i.search_init) begin
      lo_d = '0;
      hi_d = count_m1[IdxW-1:0];
    end
    if (cmd_i.step) begin
      if (rd_data_q >= value_q) begin
        hi_d = mid;
      end else begin
        lo_d = mid + IdxW'(1);
      end
    end
    if (cmd_i.finish) begin
      bucket_d = BucketW'(lo_plus1);
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
      done_q  <= cmd_i.exec || cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_e'(func_i);
      value_q <= item_value_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    bucket_q <= bucket_d;
    status_q <= status_d;
  end

  // Running-total memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IdxW-1:0]] <= sum_sat;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[mid];
    end
  end

  assign done_o          = done_q;
  assign bucket_number_o = bucket_q;
  assign status_o        = status_q;

endmodule

@@ rtl/core/prefix_sum_bucket_locator.sv @@
// Append, restart, rejected query and unused code finish from the DECIDE state; a searched
// query then walks READ/COMPARE pairs, one registered memory read per search step, and
// finishes in READ once the search interval holds a single entry.
// One request is in flight at a time; busy is high from acceptance until the result.
// Reset clears the entry count, running total and controller; the memory keeps its
// contents but is never read beyond the entry count. The receiver cannot stall results.
module prefix_sum_bucket_locator
  import psbl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [ValueW-1:0]  item_value_i,
  output logic               done_o,
  output logic [BucketW-1:0] bucket_number_o,
  output logic [1:0]         status_o
);

  // The controller issues at most one command per cycle; the datapath answers with two
  // status flags. A query walks a DECIDE, then READ/COMPARE pairs: READ puts the
  // midpoint total into the read register, COMPARE narrows the bounds with it.
  psbl_cmd_t cmd;
  psbl_sts_t sts;

  psbl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // The datapath holds the table of running totals, the entry count, the
  // saturating grand total and the registered result with its one-cycle strobe.
  psbl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .item_value_i    (item_value_i),
    .sts_o           (sts),
    .done_o          (done_o),
    .bucket_number_o (bucket_number_o),
    .status_o        (status_o)
  );

  // A result is only ever produced by a request that was in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A request that ends with an error status never reports a bucket.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (bucket_number_o == '0))
    else $error("bucket reported together with an error status");

  // The controller never issues a read and a compare, or an immediate result and a finish, in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd && cmd.step) && !(cmd.exec && cmd.finish))
    else $error("conflicting datapath commands");

endmodule
